// File: sv/k_way_sorted_list_merge_defines.svh
// Assertion macros shared by the k-way merge RTL.
// Depends on nothing; users provide signals named clock and reset.
`ifndef K_WAY_SORTED_LIST_MERGE_DEFINES_SVH
`define K_WAY_SORTED_LIST_MERGE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KWSM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define KWSM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/kwsm_pkg.sv
// Shared sizes, payload structs and control structs of the k-way merge.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package kwsm_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int MAX_LISTS    = 8;
   localparam int DATA_W       = 32;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int LIST_W       = $clog2(MAX_LISTS);
   localparam int LCNT_W       = $clog2(MAX_LISTS + 1);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     end_of_list;
      logic                     end_of_load;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] merged_value;
      logic                     last_of_run;
      logic                     overflow;
   } rsp_type;

   // Control into the shared compare unit.
   typedef struct packed {
      logic              clear;
      logic              take;
      logic [LIST_W-1:0] list;
      logic [CNT_W-1:0]  head;
   } best_ctl_type;

   // Running winner of the compare unit.
   typedef struct packed {
      logic                     have;
      logic [LIST_W-1:0]        list;
      logic [CNT_W-1:0]         head;
      logic signed [DATA_W-1:0] value;
   } best_sts_type;

endpackage

`default_nettype wire

// File: sv/kwsm_mem.sv
// Element store of the k-way merge: one write port, one registered read port.
// Depends on kwsm_pkg.
`default_nettype none

module kwsm_mem
   import kwsm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic signed [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output logic signed [DATA_W-1:0]      rd_data
);

   logic signed [DATA_W-1:0] mem_ff [MAX_ELEMENTS];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/kwsm_best.sv
// Shared signed compare unit: keeps the smallest head seen in one scan.
// Depends on kwsm_pkg.
`default_nettype none

module kwsm_best
   import kwsm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire best_ctl_type             ctl,
   input  wire logic signed [DATA_W-1:0] data,
   output best_sts_type                  sts
);

   best_sts_type best_ff;
   best_sts_type best_in;

   // Strict less-than keeps the lower-numbered list on ties.
   always_comb begin
      best_in = best_ff;
      if (ctl.clear) begin
         best_in.have = 1'b0;
      end else if (ctl.take && (!best_ff.have || (data < best_ff.value))) begin
         best_in.have  = 1'b1;
         best_in.list  = ctl.list;
         best_in.head  = ctl.head;
         best_in.value = data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff.have <= 1'b0;
      end else begin
         best_ff.have <= best_in.have;
      end
      best_ff.list  <= best_in.list;
      best_ff.head  <= best_in.head;
      best_ff.value <= best_in.value;
   end

   assign sts = best_ff;

endmodule

`default_nettype wire

// File: sv/k_way_sorted_list_merge.sv
// Top level of the k-way merge: load sequencer, list table, output register.
// Depends on kwsm_pkg, kwsm_mem, kwsm_best and k_way_sorted_list_merge_defines.svh.
//
//   channel | ports                          | carries
//   --------+--------------------------------+------------------------------------
//   request | req_valid, req_ready, req_data | one element with end-of-list/load
//   result  | rsp_valid, rsp_ready, rsp_data | merged value, last flag, overflow
//
// Loading accepts one request per cycle; req_ready is high only while loading.
// Each result scans the list heads, one per cycle, through the single compare
// unit, then drains the memory read, then emits.
// A full result register that is not taken holds the merge in its emit step.
// Reset clears the list table and counters; the element store needs no clear.
`default_nettype none

`include "k_way_sorted_list_merge_defines.svh"

module k_way_sorted_list_merge
   import kwsm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_PICK = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [CNT_W-1:0]  start_ff [MAX_LISTS];
   logic [CNT_W-1:0]  start_in [MAX_LISTS];
   logic [CNT_W-1:0]  head_ff  [MAX_LISTS];
   logic [CNT_W-1:0]  head_in  [MAX_LISTS];
   logic [CNT_W-1:0]  end_ff   [MAX_LISTS];
   logic [CNT_W-1:0]  end_in   [MAX_LISTS];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LCNT_W-1:0] lc_ff, lc_in;
   logic              dropped_ff, dropped_in;
   logic [CNT_W-1:0]  remaining_ff, remaining_in;
   logic [LIST_W-1:0] k_ff, k_in;
   best_ctl_type      pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic                     req_fire;
   logic                     room;
   logic                     store_en;
   logic                     lists_open;
   logic                     close_list;
   logic [LIST_W-1:0]        lc_idx;
   logic [CNT_W-1:0]         count_next;
   logic                     emit_fire;
   logic signed [DATA_W-1:0] rd_data;
   best_ctl_type             best_ctl;
   best_sts_type             best_sts;

   assign req_ready  = (state_ff == ST_LOAD);
   assign req_fire   = req_valid && req_ready;
   assign lists_open = (lc_ff < LCNT_W'(MAX_LISTS));
   assign room       = lists_open && (count_ff < CNT_W'(MAX_ELEMENTS));
   assign store_en   = req_fire && room;
   assign count_next = count_ff + CNT_W'(store_en);
   assign lc_idx     = lc_ff[LIST_W-1:0];
   // Both marks close the current list while a slot for it remains.
   assign close_list = req_fire && (req_data.end_of_list || req_data.end_of_load)
                       && lists_open;
   assign emit_fire  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   kwsm_mem u_mem (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (head_ff[k_ff][ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Clear the winner at the start of each scan; the registered memory read
   // lands together with its registered pending tag.
   always_comb begin
      best_ctl       = pend_ff;
      best_ctl.clear = (state_ff == ST_SCAN) && (k_ff == '0);
   end

   kwsm_best u_best (
      .clock (clock),
      .reset (reset),
      .ctl   (best_ctl),
      .data  (rd_data),
      .sts   (best_sts)
   );

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      head_in      = head_ff;
      end_in       = end_ff;
      count_in     = count_ff;
      lc_in        = lc_ff;
      dropped_in   = dropped_ff;
      remaining_in = remaining_ff;
      k_in         = k_ff;
      pend_in      = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_LOAD: begin
            count_in = count_next;
            if (req_fire && !room) begin
               dropped_in = 1'b1;
            end
            if (close_list) begin
               end_in[lc_idx]  = count_next;
               head_in[lc_idx] = start_ff[lc_idx];
               lc_in           = lc_ff + LCNT_W'(1);
               if (lc_idx != LIST_W'(MAX_LISTS - 1)) begin
                  start_in[lc_idx + LIST_W'(1)] = count_next;
               end
            end
            if (req_fire && req_data.end_of_load) begin
               remaining_in = count_next;
               k_in         = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one head read per cycle; tag it for the compare unit.
            pend_in.take = (head_ff[k_ff] < end_ff[k_ff]);
            pend_in.list = k_ff;
            pend_in.head = head_ff[k_ff];
            k_in         = k_ff + LIST_W'(1);
            if (k_ff == LIST_W'(MAX_LISTS - 1)) begin
               k_in     = '0;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in           = 1'b1;
               rsp_in.merged_value    = best_sts.value;
               rsp_in.last_of_run     = (remaining_ff == CNT_W'(1));
               rsp_in.overflow        = dropped_ff;
               head_in[best_sts.list] = best_sts.head + CNT_W'(1);
               remaining_in           = remaining_ff - CNT_W'(1);
               if (remaining_ff == CNT_W'(1)) begin
                  // Drop the finished load and start an empty one.
                  for (int i = 0; i < MAX_LISTS; i++) begin
                     start_in[i] = '0;
                     head_in[i]  = '0;
                     end_in[i]   = '0;
                  end
                  count_in   = '0;
                  lc_in      = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  k_in     = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         start_ff     <= '{default: '0};
         head_ff      <= '{default: '0};
         end_ff       <= '{default: '0};
         count_ff     <= '0;
         lc_ff        <= '0;
         dropped_ff   <= 1'b0;
         remaining_ff <= '0;
         k_ff         <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         head_ff      <= head_in;
         end_ff       <= end_in;
         count_ff     <= count_in;
         lc_ff        <= lc_in;
         dropped_ff   <= dropped_in;
         remaining_ff <= remaining_in;
         k_ff         <= k_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `KWSM_ASSERT_NOW(a_merge_has_work, (state_ff != ST_LOAD), (remaining_ff != '0),
      "merge running with nothing left to emit")
   `KWSM_ASSERT_NOW(a_emit_has_winner, (state_ff == ST_EMIT), best_sts.have,
      "emit step without a winning list head")
   `KWSM_ASSERT_NEXT(a_last_clears_load, (emit_fire && (remaining_ff == CNT_W'(1))),
      ((state_ff == ST_LOAD) && (count_ff == '0) && (lc_ff == '0) && !dropped_ff),
      "load not cleared after the final result")
   `KWSM_ASSERT_NOW(a_count_bound, 1'b1, (count_ff <= CNT_W'(MAX_ELEMENTS)),
      "element count beyond the store depth")

endmodule

`default_nettype wire
